// ----- hdl/palbl_pkg.sv -----
// Shared types and constants for the per-address leaky bucket limiter.
// No dependencies; used by the interfaces and the top level.
package palbl_pkg;

  // Table sizes
  localparam int NumEntries = 1024;
  localparam int NumGlobal  = 8;
  localparam int EntryIdxW  = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int EntryCntW  = $clog2(NumEntries + 1);
  localparam int GlobIdxW   = (NumGlobal > 1) ? $clog2(NumGlobal) : 1;

  // Field widths
  localparam int TimeW   = 63;
  localparam int AddrW   = 32;
  localparam int LevelW  = 8;
  localparam int PeriodW = 16;
  localparam int DivCntW = $clog2(TimeW + 1);

  // Action codes (the spare code behaves as ActBoth)
  localparam logic [1:0] ActAddr = 2'd0;
  localparam logic [1:0] ActGlob = 2'd1;
  localparam logic [1:0] ActBoth = 2'd2;
  localparam logic [1:0] ActRsvd = 2'd3;

  // Result codes
  localparam logic [1:0] LimNone = 2'd0;
  localparam logic [1:0] LimAddr = 2'd1;
  localparam logic [1:0] LimGlob = 2'd2;

  // One word of the address table
  typedef struct packed {
    logic              live;
    logic [AddrW-1:0]  address;
    logic [TimeW-1:0]  last_time;
    logic [LevelW-1:0] level;
  } entry_t;

endpackage

// ----- hdl/palbl_req_if.sv -----
// Request channel of the limiter: valid/ready handshake and request fields.
// Depends on palbl_pkg.
interface palbl_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic [palbl_pkg::AddrW-1:0]    source_address;
  logic [2:0]                     global_index;
  logic [palbl_pkg::TimeW-1:0]    now_ms;
  logic [palbl_pkg::LevelW-1:0]   addr_burst;
  logic [palbl_pkg::PeriodW-1:0]  addr_period;
  logic [palbl_pkg::LevelW-1:0]   glob_burst;
  logic [palbl_pkg::PeriodW-1:0]  glob_period;

  modport source (
    output valid, action, source_address, global_index, now_ms,
           addr_burst, addr_period, glob_burst, glob_period,
    input  ready
  );
  modport sink (
    input  valid, action, source_address, global_index, now_ms,
           addr_burst, addr_period, glob_burst, glob_period,
    output ready
  );
endinterface

// Result channel of the limiter: valid/ready handshake and decision fields.
interface palbl_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] limited_by;
  logic       table_full;

  modport source (output valid, limited_by, table_full, input ready);
  modport sink   (input  valid, limited_by, table_full, output ready);
endinterface

// ----- hdl/per_address_leaky_bucket_limiter.sv -----
// Per-address leaky bucket limiter with a bank of global buckets; uses palbl_pkg and the
// interfaces in palbl_req_if.sv. An accepted request scans the address table (not for global
// only), runs a restoring divide and an update for each bucket charged (a full table skips
// them), then loads the output register. One request in flight; the next is taken the cycle
// after the result is registered. Reset: a clearing pass over all NumEntries entries wipes
// the table before requests are taken.
module per_address_leaky_bucket_limiter (
  input  logic         clk_i,
  input  logic         rst_ni,
  palbl_req_if.sink    req_i,
  palbl_res_if.source  res_o
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StScan,
    StDiv,
    StApply,
    StDone
  } state_e;

  state_e state_q;

  // Table memory
  palbl_pkg::entry_t mem_q [palbl_pkg::NumEntries];
  palbl_pkg::entry_t rd_data_q;
  logic                           mem_re;
  logic [palbl_pkg::EntryIdxW-1:0] mem_raddr;
  logic                           mem_we;
  logic [palbl_pkg::EntryIdxW-1:0] mem_waddr;
  palbl_pkg::entry_t              mem_wdata;

  // Global buckets
  logic [palbl_pkg::TimeW-1:0]  glob_last_q [palbl_pkg::NumGlobal];
  logic [palbl_pkg::LevelW-1:0] glob_lvl_q  [palbl_pkg::NumGlobal];

  // Request registers
  logic [1:0]                       action_q;
  logic [palbl_pkg::AddrW-1:0]      addr_q;
  logic [palbl_pkg::GlobIdxW-1:0]   gsel_q;
  logic [palbl_pkg::TimeW-1:0]      now_q;
  logic [palbl_pkg::LevelW-1:0]     a_burst_q;
  logic [palbl_pkg::PeriodW-1:0]    a_period_q;
  logic [palbl_pkg::LevelW-1:0]     g_burst_q;
  logic [palbl_pkg::PeriodW-1:0]    g_period_q;
  logic [palbl_pkg::LevelW+palbl_pkg::PeriodW-1:0] limit_q;

  // Scan bookkeeping
  logic [palbl_pkg::EntryCntW-1:0]  scan_cnt_q;
  logic                             rd_vld_q;
  logic [palbl_pkg::EntryIdxW-1:0]  rd_idx_q;
  logic                             hit_q;
  logic                             free_q;
  logic [palbl_pkg::EntryIdxW-1:0]  hit_idx_q;
  logic [palbl_pkg::EntryIdxW-1:0]  free_idx_q;
  logic [palbl_pkg::TimeW-1:0]      hit_last_q;
  logic [palbl_pkg::LevelW-1:0]     hit_lvl_q;
  logic [palbl_pkg::EntryIdxW-1:0]  clr_idx_q;

  // Bucket being charged
  logic                             is_glob_q;
  logic [palbl_pkg::EntryIdxW-1:0]  cur_idx_q;
  logic [palbl_pkg::TimeW-1:0]      cur_last_q;
  logic [palbl_pkg::LevelW-1:0]     cur_lvl_q;
  logic [palbl_pkg::LevelW-1:0]     cur_burst_q;
  logic [palbl_pkg::PeriodW-1:0]    cur_period_q;

  // Divider
  logic [palbl_pkg::TimeW-1:0]      dvd_q;
  logic [palbl_pkg::TimeW-1:0]      quot_q;
  logic [palbl_pkg::PeriodW-1:0]    rem_q;
  logic [palbl_pkg::DivCntW-1:0]    div_cnt_q;

  // Decision of the request in flight
  logic [1:0] dec_by_q;
  logic       dec_full_q;

  // Output register
  logic       out_vld_q;
  logic [1:0] out_by_q;
  logic       out_full_q;

  assign req_i.ready      = (state_q == StIdle);
  assign res_o.valid      = out_vld_q;
  assign res_o.limited_by = out_by_q;
  assign res_o.table_full = out_full_q;

  // Address period with zero read as one
  logic [palbl_pkg::PeriodW-1:0] a_period_in;
  assign a_period_in = (req_i.addr_period == '0) ? palbl_pkg::PeriodW'(1) : req_i.addr_period;

  // Scan compare on the registered read word
  logic                        rd_match;
  logic                        rd_free;
  logic [palbl_pkg::TimeW-1:0] rd_age;
  always_comb begin
    rd_age   = now_q - rd_data_q.last_time;
    rd_match = rd_data_q.live && (rd_data_q.address == addr_q);
    rd_free  = !rd_data_q.live || (now_q < rd_data_q.last_time) ||
               (rd_age > palbl_pkg::TimeW'(limit_q));
  end

  // Divider step
  logic [palbl_pkg::PeriodW:0] trial;
  logic                        trial_ge;
  always_comb begin
    trial    = {rem_q, dvd_q[palbl_pkg::TimeW-1]};
    trial_ge = (trial >= {1'b0, cur_period_q});
  end

  // Drain and fill of the current bucket
  logic                         back;
  logic                         empty;
  logic [palbl_pkg::LevelW-1:0] lvl_dr;
  logic [palbl_pkg::TimeW-1:0]  last_dr;
  logic                         limited;
  logic [palbl_pkg::LevelW-1:0] lvl_new;
  always_comb begin
    back  = (now_q < cur_last_q);
    empty = back ||
            (quot_q > {{(palbl_pkg::TimeW-palbl_pkg::LevelW){1'b0}}, cur_lvl_q});
    if (empty) begin
      lvl_dr  = '0;
      last_dr = now_q;
    end else begin
      lvl_dr  = cur_lvl_q - quot_q[palbl_pkg::LevelW-1:0];
      last_dr = now_q - palbl_pkg::TimeW'(rem_q);
    end
    limited = !(lvl_dr < cur_burst_q);
    lvl_new = limited ? lvl_dr : lvl_dr + palbl_pkg::LevelW'(1);
  end

  // Memory port control
  always_comb begin
    mem_re    = (state_q == StScan) && (scan_cnt_q < palbl_pkg::EntryCntW'(palbl_pkg::NumEntries));
    mem_raddr = scan_cnt_q[palbl_pkg::EntryIdxW-1:0];
    mem_we    = 1'b0;
    mem_waddr = cur_idx_q;
    mem_wdata = '{live: 1'b1, address: addr_q, last_time: last_dr, level: lvl_new};
    if (state_q == StClear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else if (state_q == StApply && !is_glob_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // Control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_idx_q  <= '0;
      out_vld_q  <= 1'b0;
      out_by_q   <= palbl_pkg::LimNone;
      out_full_q <= 1'b0;
      dec_by_q   <= palbl_pkg::LimNone;
      dec_full_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      is_glob_q  <= 1'b0;
      scan_cnt_q <= '0;
      div_cnt_q  <= '0;
      for (int g = 0; g < palbl_pkg::NumGlobal; g++) begin
        glob_last_q[g] <= '0;
        glob_lvl_q[g]  <= '0;
      end
    end else begin
      // Result register: load from the decision, or empty on acceptance
      if (state_q == StDone && (!out_vld_q || res_o.ready)) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          clr_idx_q <= clr_idx_q + palbl_pkg::EntryIdxW'(1);
          if (clr_idx_q == palbl_pkg::EntryIdxW'(palbl_pkg::NumEntries - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (req_i.valid) begin
            action_q   <= req_i.action;
            addr_q     <= req_i.source_address;
            gsel_q     <= palbl_pkg::GlobIdxW'(req_i.global_index % palbl_pkg::NumGlobal);
            now_q      <= req_i.now_ms;
            a_burst_q  <= req_i.addr_burst;
            a_period_q <= a_period_in;
            g_burst_q  <= req_i.glob_burst;
            g_period_q <= (req_i.glob_period == '0) ? palbl_pkg::PeriodW'(1) : req_i.glob_period;
            limit_q    <= (palbl_pkg::LevelW+palbl_pkg::PeriodW)'(req_i.addr_burst) *
                          (palbl_pkg::LevelW+palbl_pkg::PeriodW)'(a_period_in);
            scan_cnt_q <= '0;
            rd_vld_q   <= 1'b0;
            hit_q      <= 1'b0;
            free_q     <= 1'b0;
            if (req_i.action == palbl_pkg::ActGlob) begin
              // Global only: start the divide for the global bucket
              is_glob_q    <= 1'b1;
              cur_last_q   <= glob_last_q[palbl_pkg::GlobIdxW'(req_i.global_index % palbl_pkg::NumGlobal)];
              cur_lvl_q    <= glob_lvl_q[palbl_pkg::GlobIdxW'(req_i.global_index % palbl_pkg::NumGlobal)];
              cur_burst_q  <= req_i.glob_burst;
              cur_period_q <= (req_i.glob_period == '0) ? palbl_pkg::PeriodW'(1) : req_i.glob_period;
              dvd_q        <= req_i.now_ms -
                glob_last_q[palbl_pkg::GlobIdxW'(req_i.global_index % palbl_pkg::NumGlobal)];
              quot_q       <= '0;
              rem_q        <= '0;
              div_cnt_q    <= palbl_pkg::DivCntW'(palbl_pkg::TimeW);
              state_q      <= StDiv;
            end else begin
              is_glob_q <= 1'b0;
              state_q   <= StScan;
            end
          end
        end
        StScan: begin
          // One read issued and one word compared per cycle
          rd_vld_q <= mem_re;
          rd_idx_q <= mem_raddr;
          if (mem_re) begin
            scan_cnt_q <= scan_cnt_q + palbl_pkg::EntryCntW'(1);
          end
          if (rd_vld_q) begin
            if (rd_match && !hit_q) begin
              hit_q      <= 1'b1;
              hit_idx_q  <= rd_idx_q;
              hit_last_q <= rd_data_q.last_time;
              hit_lvl_q  <= rd_data_q.level;
            end
            if (rd_free && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= rd_idx_q;
            end
          end
          if (!mem_re && !rd_vld_q) begin
            cur_burst_q  <= a_burst_q;
            cur_period_q <= a_period_q;
            quot_q       <= '0;
            rem_q        <= '0;
            div_cnt_q    <= palbl_pkg::DivCntW'(palbl_pkg::TimeW);
            if (hit_q) begin
              cur_idx_q  <= hit_idx_q;
              cur_last_q <= hit_last_q;
              cur_lvl_q  <= hit_lvl_q;
              dvd_q      <= now_q - hit_last_q;
              state_q    <= StDiv;
            end else if (free_q) begin
              // Claimed entry starts empty at the current time
              cur_idx_q  <= free_idx_q;
              cur_last_q <= now_q;
              cur_lvl_q  <= '0;
              dvd_q      <= '0;
              state_q    <= StDiv;
            end else begin
              dec_by_q   <= palbl_pkg::LimAddr;
              dec_full_q <= 1'b1;
              state_q    <= StDone;
            end
          end
        end
        StDiv: begin
          // Restoring divide, one quotient bit per cycle
          dvd_q     <= {dvd_q[palbl_pkg::TimeW-2:0], 1'b0};
          quot_q    <= {quot_q[palbl_pkg::TimeW-2:0], trial_ge};
          rem_q     <= trial_ge ? palbl_pkg::PeriodW'(trial - {1'b0, cur_period_q})
                                : trial[palbl_pkg::PeriodW-1:0];
          div_cnt_q <= div_cnt_q - palbl_pkg::DivCntW'(1);
          if (div_cnt_q == palbl_pkg::DivCntW'(1)) begin
            state_q <= StApply;
          end
        end
        StApply: begin
          dec_full_q <= 1'b0;
          if (is_glob_q) begin
            glob_last_q[gsel_q] <= last_dr;
            glob_lvl_q[gsel_q]  <= lvl_new;
            dec_by_q <= limited ? palbl_pkg::LimGlob : palbl_pkg::LimNone;
            state_q  <= StDone;
          end else if (!limited && action_q != palbl_pkg::ActAddr) begin
            // Address admitted: go on to the global bucket
            is_glob_q    <= 1'b1;
            cur_last_q   <= glob_last_q[gsel_q];
            cur_lvl_q    <= glob_lvl_q[gsel_q];
            cur_burst_q  <= g_burst_q;
            cur_period_q <= g_period_q;
            dvd_q        <= now_q - glob_last_q[gsel_q];
            quot_q       <= '0;
            rem_q        <= '0;
            div_cnt_q    <= palbl_pkg::DivCntW'(palbl_pkg::TimeW);
            state_q      <= StDiv;
          end else begin
            dec_by_q <= limited ? palbl_pkg::LimAddr : palbl_pkg::LimNone;
            state_q  <= StDone;
          end
        end
        StDone: begin
          // Wait for the result register to free up
          if (!out_vld_q || res_o.ready) begin
            out_by_q   <= dec_by_q;
            out_full_q <= dec_full_q;
            state_q    <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Checks
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> !mem_we)
    else $error("table written during scan");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == StScan || state_q == StDiv))
    else $error("accepted request did not start work");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && div_cnt_q != palbl_pkg::DivCntW'(1)) |=> (state_q == StDiv))
    else $error("divider left early");

  a_full_is_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_full_q) |-> (out_by_q == palbl_pkg::LimAddr))
    else $error("table full without address limit");

endmodule

// ----- tb/per_address_leaky_bucket_limiter_tb.sv -----
// Testbench for the per-address leaky bucket limiter: a directed table, then random requests.
// Results are checked against a behavioral bucket predictor kept in the testbench.
// Depends on palbl_pkg, palbl_req_if.sv and the limiter top level.
module per_address_leaky_bucket_limiter_tb;

  localparam int WatchdogLimit = 40000;
  localparam int NumDirected   = 16;

  typedef struct {
    logic [1:0]                    action;
    logic [palbl_pkg::AddrW-1:0]   addr;
    logic [2:0]                    gidx;
    logic [palbl_pkg::TimeW-1:0]   now;
    logic [palbl_pkg::LevelW-1:0]  a_burst;
    logic [palbl_pkg::PeriodW-1:0] a_period;
    logic [palbl_pkg::LevelW-1:0]  g_burst;
    logic [palbl_pkg::PeriodW-1:0] g_period;
    logic                          typed;   // expected decision written in the row
    logic [1:0]                    exp_by;
    logic                          exp_full;
  } request_row_t;

  typedef struct {
    logic [1:0] by;
    logic       full;
  } decision_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  palbl_req_if req_if();
  palbl_res_if res_if();

  per_address_leaky_bucket_limiter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .res_o  (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic                          tbl_live  [palbl_pkg::NumEntries];
  logic [palbl_pkg::AddrW-1:0]   tbl_addr  [palbl_pkg::NumEntries];
  logic [63:0]                   tbl_last  [palbl_pkg::NumEntries];
  logic [palbl_pkg::LevelW-1:0]  tbl_level [palbl_pkg::NumEntries];
  logic [63:0]                   glb_last  [palbl_pkg::NumGlobal];
  logic [palbl_pkg::LevelW-1:0]  glb_level [palbl_pkg::NumGlobal];

  decision_t    pending_decisions[$];
  request_row_t directed_rows[NumDirected];
  int  fail_count = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  logic [palbl_pkg::AddrW-1:0] addr_pool[8];

  // Drain whole periods, then fill by one below the burst; returns 1 when limited
  function automatic logic drain_and_fill(inout logic [63:0] last, inout logic [7:0] level,
                                          input logic [63:0] now, input logic [7:0] burst,
                                          input logic [63:0] period);
    logic [63:0] diff;
    logic [63:0] whole;
    if (now < last) begin
      level = '0;
      last  = now;
    end else begin
      diff  = now - last;
      whole = diff / period;
      if (whole > {56'd0, level}) begin
        level = '0;
        last  = now;
      end else begin
        level = level - whole[7:0];
        last  = now - (diff % period);
      end
    end
    if (level < burst) begin
      level = level + 8'd1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Hit search, then reclaiming scan; -1 when the table is full
  function automatic int bucket_slot(logic [palbl_pkg::AddrW-1:0] addr, logic [63:0] now,
                                     logic [63:0] max_age);
    for (int i = 0; i < palbl_pkg::NumEntries; i++)
      if (tbl_live[i] && tbl_addr[i] == addr) return i;
    for (int i = 0; i < palbl_pkg::NumEntries; i++) begin
      if (tbl_live[i] && (now < tbl_last[i] || now - tbl_last[i] > max_age)) begin
        tbl_live[i] = 1'b0; tbl_addr[i] = '0; tbl_last[i] = '0; tbl_level[i] = '0;
      end
      if (!tbl_live[i]) begin
        tbl_live[i] = 1'b1; tbl_addr[i] = addr; tbl_last[i] = now; tbl_level[i] = '0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic decision_t predict_decision(request_row_t r);
    decision_t   d;
    logic [63:0] now, ap, gp, lst;
    logic [7:0]  lvl;
    int          slot, g;
    d.by = palbl_pkg::LimNone; d.full = 1'b0;
    now = {1'b0, r.now};
    ap = (r.a_period == 0) ? 64'd1 : {48'd0, r.a_period};
    gp = (r.g_period == 0) ? 64'd1 : {48'd0, r.g_period};
    g = r.gidx % palbl_pkg::NumGlobal;
    if (r.action != palbl_pkg::ActGlob) begin
      slot = bucket_slot(r.addr, now, {56'd0, r.a_burst} * ap);
      if (slot < 0) begin
        d.by = palbl_pkg::LimAddr; d.full = 1'b1;
      end else begin
        lst = tbl_last[slot]; lvl = tbl_level[slot];
        if (drain_and_fill(lst, lvl, now, r.a_burst, ap)) d.by = palbl_pkg::LimAddr;
        tbl_last[slot] = lst; tbl_level[slot] = lvl;
      end
    end
    if (d.by == palbl_pkg::LimNone && r.action != palbl_pkg::ActAddr) begin
      lst = glb_last[g]; lvl = glb_level[g];
      if (drain_and_fill(lst, lvl, now, r.g_burst, gp)) d.by = palbl_pkg::LimGlob;
      glb_last[g] = lst; glb_level[g] = lvl;
    end
    return d;
  endfunction

  // Send one request with random sender gaps; called and returning at a falling edge
  task automatic send_request(request_row_t r);
    decision_t d;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.action         <= r.action;
    req_if.source_address <= r.addr;
    req_if.global_index   <= r.gidx;
    req_if.now_ms         <= r.now;
    req_if.addr_burst     <= r.a_burst;
    req_if.addr_period    <= r.a_period;
    req_if.glob_burst     <= r.g_burst;
    req_if.glob_period    <= r.g_period;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    d = predict_decision(r);
    if (r.typed && (d.by != r.exp_by || d.full != r.exp_full)) begin
      $error("directed row disagrees with predictor: by %0d/%0d full %0d/%0d",
             r.exp_by, d.by, r.exp_full, d.full);
      fail_count++;
    end
    pending_decisions.push_back(d);
    @(negedge clk_i);
  endtask

  function automatic request_row_t random_request(logic [63:0] now);
    request_row_t r;
    r.action   = ($urandom_range(19) == 0) ? palbl_pkg::ActRsvd : 2'($urandom_range(2));
    r.addr     = ($urandom_range(3) == 0) ? $urandom : addr_pool[$urandom_range(7)];
    r.gidx     = 3'($urandom);
    r.now      = now[62:0];
    r.a_burst  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4));
    r.a_period = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    r.g_burst  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6));
    r.g_period = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    r.typed = 1'b0; r.exp_by = palbl_pkg::LimNone; r.exp_full = 1'b0;
    return r;
  endfunction

  // Result side: random stalls, compare with the oldest expectation
  always @(negedge clk_i)
    res_if.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    decision_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_decisions.size() == 0) begin
        $error("unexpected result: limited_by %0d table_full %0d",
               res_if.limited_by, res_if.table_full);
        fail_count++;
      end else begin
        e = pending_decisions.pop_front();
        if (res_if.limited_by !== e.by) begin
          $error("limited_by: expected %0d actual %0d", e.by, res_if.limited_by);
          fail_count++;
        end
        if (res_if.table_full !== e.full) begin
          $error("table_full: expected %0d actual %0d", e.full, res_if.table_full);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("per_address_leaky_bucket_limiter: mismatch");
      $finish;
    end
  end

  initial begin
    logic [63:0] clock_ms;
    logic [63:0] wild_ms;
    request_row_t r;
    // action, addr, gidx, now, a_burst, a_period, g_burst, g_period, typed, by, full
    directed_rows = '{
      '{palbl_pkg::ActAddr, 32'h0A000001, 3'd0, 63'd0, 8'd0, 16'd1, 8'd0, 16'd1,
        1'b1, palbl_pkg::LimAddr, 1'b0},
      '{palbl_pkg::ActAddr, 32'h0A000001, 3'd0, 63'd0, 8'd2, 16'd0, 8'd0, 16'd1,
        1'b1, palbl_pkg::LimNone, 1'b0},
      '{palbl_pkg::ActAddr, 32'h0A000001, 3'd0, 63'd0, 8'd2, 16'd0, 8'd0, 16'd1,
        1'b1, palbl_pkg::LimNone, 1'b0},
      '{palbl_pkg::ActAddr, 32'h0A000001, 3'd0, 63'd0, 8'd2, 16'd0, 8'd0, 16'd1,
        1'b1, palbl_pkg::LimAddr, 1'b0},
      '{palbl_pkg::ActAddr, 32'h0A000001, 3'd0, 63'd5, 8'd2, 16'd3, 8'd0, 16'd1,
        1'b0, palbl_pkg::LimNone, 1'b0},
      '{palbl_pkg::ActGlob, 32'hFFFFFFFF, 3'd7, 63'd10, 8'd1, 16'd100, 8'd0, 16'd1,
        1'b1, palbl_pkg::LimGlob, 1'b0},
      '{palbl_pkg::ActGlob, 32'hFFFFFFFF, 3'd7, 63'd10, 8'd0, 16'd100, 8'd1, 16'hFFFF,
        1'b1, palbl_pkg::LimNone, 1'b0},
      '{palbl_pkg::ActGlob, 32'hFFFFFFFF, 3'd7, 63'd11, 8'd0, 16'd100, 8'd1, 16'hFFFF,
        1'b1, palbl_pkg::LimGlob, 1'b0},
      '{palbl_pkg::ActBoth, 32'h00000000, 3'd2, 63'd20, 8'd255, 16'hFFFF, 8'd255, 16'd0,
        1'b1, palbl_pkg::LimNone, 1'b0},
      '{palbl_pkg::ActBoth, 32'hC0A80001, 3'd2, 63'd20, 8'd0, 16'd1, 8'd255, 16'd1,
        1'b1, palbl_pkg::LimAddr, 1'b0},
      '{palbl_pkg::ActRsvd, 32'h00000000, 3'd2, 63'd21, 8'd255, 16'hFFFF, 8'd0, 16'd1,
        1'b1, palbl_pkg::LimGlob, 1'b0},
      '{palbl_pkg::ActAddr, 32'h0A000001, 3'd0, 63'd2, 8'd2, 16'd3, 8'd0, 16'd1,
        1'b0, palbl_pkg::LimNone, 1'b0},
      '{palbl_pkg::ActGlob, 32'h12345678, 3'd3, 63'h7FFFFFFFFFFFFFFF, 8'd0, 16'd1, 8'd3, 16'd7,
        1'b0, palbl_pkg::LimNone, 1'b0},
      '{palbl_pkg::ActGlob, 32'h12345678, 3'd3, 63'd100, 8'd0, 16'd1, 8'd3, 16'd7,
        1'b0, palbl_pkg::LimNone, 1'b0},
      '{palbl_pkg::ActAddr, 32'h55AA55AA, 3'd5, 63'h7FFFFFFFFFFFFFFF, 8'd1, 16'd1, 8'd0, 16'd1,
        1'b0, palbl_pkg::LimNone, 1'b0},
      '{palbl_pkg::ActAddr, 32'hAA55AA55, 3'd5, 63'd200, 8'd1, 16'd1, 8'd0, 16'd1,
        1'b0, palbl_pkg::LimNone, 1'b0}
    };
    for (int i = 0; i < palbl_pkg::NumEntries; i++) begin
      tbl_live[i] = 1'b0; tbl_addr[i] = '0; tbl_last[i] = '0; tbl_level[i] = '0;
    end
    for (int i = 0; i < palbl_pkg::NumGlobal; i++) begin
      glb_last[i] = '0; glb_level[i] = '0;
    end
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    req_if.valid = 1'b0; req_if.action = palbl_pkg::ActAddr; req_if.source_address = '0;
    req_if.global_index = '0; req_if.now_ms = '0; req_if.addr_burst = '0;
    req_if.addr_period = 16'd1; req_if.glob_burst = '0; req_if.glob_period = 16'd1;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) send_request(directed_rows[i]);
    req_if.valid <= 1'b0;

    // Sender pauses until the limiter has drained all results
    while (pending_decisions.size() != 0) @(negedge clk_i);

    // Random phases: no idling, sender idle, receiver stalling, both
    clock_ms = 300;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 14 : 61) : 0;
      stall_pct     = (phase == 2 || phase == 3) ? ((phase == 3) ? 14 : 61) : 0;
      for (int n = 0; n < 131; n++) begin
        case ($urandom_range(19))
          0: clock_ms = clock_ms - $urandom_range(50);
          1: clock_ms = clock_ms + $urandom_range(100000);
          default: clock_ms = clock_ms + $urandom_range(6);
        endcase
        r = random_request(clock_ms);
        if ($urandom_range(49) == 0) begin
          wild_ms = {$urandom, $urandom};
          r.now   = wild_ms[62:0];
        end
        send_request(r);
      end
    end
    req_if.valid <= 1'b0;

    while (pending_decisions.size() != 0) @(negedge clk_i);
    repeat (1200) @(negedge clk_i);
    if (fail_count == 0) $display("per_address_leaky_bucket_limiter: match");
    else $display("per_address_leaky_bucket_limiter: mismatch");
    $finish;
  end

endmodule
